[sv/edw_pkg.sv]
// Shared types and constants for the escalating dual watchdog.
`timescale 1ns / 1ps

package edw_pkg;

  localparam int TICK_BITS  = 32;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 32;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 56;
  // compare width covers both the tick difference and a 32-bit timeout
  localparam int CMP_W      = (TICK_BITS > 32) ? TICK_BITS : 32;

  typedef logic [TICK_BITS-1:0] tick_t;
  typedef logic [31:0]          ms_t;
  typedef logic [CMP_W-1:0]     cmp_t;
  typedef logic [7:0]           count_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_BUSY_TIMEOUT = 2'd0,
    REG_SOFT_LIMIT   = 2'd1,
    REG_LIVE_TIMEOUT = 2'd2,
    REG_LIVE_LIMIT   = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ACT_NONE    = 2'd0,
    ACT_SOFT    = 2'd1,
    ACT_RESTART = 2'd2,
    ACT_HARD    = 2'd3
  } action_t;

  localparam ms_t    BUSY_TIMEOUT_RST = 32'd300000;
  localparam count_t SOFT_LIMIT_RST   = 8'd2;
  localparam ms_t    LIVE_TIMEOUT_RST = 32'd600000;
  localparam count_t LIVE_LIMIT_RST   = 8'd2;

  typedef struct packed {
    count_t  live_rec;
    count_t  busy_rec;
    logic [31:0] elapsed;
    action_t action;
  } result_t;

  // Saturating increment for the recovery counts.
  function automatic count_t bump(input count_t c);
    bump = (c == 8'hFF) ? 8'hFF : c + 8'd1;
  endfunction

endpackage

[sv/escalating_dual_watchdog.sv]
// Escalating dual watchdog: busy and liveness timers with escalating recovery codes.
//
//  channel  | direction | tdata fields (low bit first)                     | tuser
//  s_axis   | in        | now_ms[31:0], module_busy[32], zero pad to 40    | mode
//  m_axis   | out       | action[1:0], elapsed_ms[33:2], busy_rec[41:34],  | -
//           |           | liveness_rec[49:42], zero pad to 56              |
//  cfg      | in        | cfg_we, cfg_addr (register index), cfg_wdata     | -
//
// One transaction per clock while s_axis_tready is high: the step is two tick subtractions
// and compares, done between the timer state and the result register.
// A two-deep output buffer (result register plus skid) keeps s_axis_tready high
// while one result waits on m_axis; tready drops only when both are full.
// rst is synchronous: timers, counts and config registers return to their defaults.
`timescale 1ns / 1ps

module escalating_dual_watchdog (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [edw_pkg::IN_DATA_W-1:0]      s_axis_tdata,  // now_ms, module_busy
  input  logic                               s_axis_tuser,  // mode
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [edw_pkg::OUT_DATA_W-1:0]     m_axis_tdata,  // action, elapsed_ms,
                                                            // busy_rec, liveness_rec
  input  logic                               cfg_we,
  input  logic [edw_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [edw_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import edw_pkg::*;

  ms_t     busy_timeout;
  count_t  soft_limit;
  ms_t     live_timeout;
  count_t  live_limit;

  tick_t   busy_stamp, busy_stamp_next;
  count_t  busy_count, busy_count_next;
  tick_t   live_stamp, live_stamp_next;
  count_t  live_count, live_count_next;

  result_t res;
  result_t out_res, skid_res;
  logic    out_valid, skid_valid;

  logic    in_take, out_take;
  logic    mode, module_busy;
  tick_t   now, diff_live, diff_busy;
  count_t  live_bumped;

  assign in_take     = s_axis_tvalid && s_axis_tready;
  assign out_take    = m_axis_tvalid && m_axis_tready;
  assign mode        = s_axis_tuser;
  assign now         = tick_t'(s_axis_tdata[31:0]);
  assign module_busy = s_axis_tdata[32];
  assign diff_live   = now - live_stamp;
  assign diff_busy   = now - busy_stamp;
  assign live_bumped = bump(live_count);

  always_comb begin
    busy_stamp_next = busy_stamp;
    busy_count_next = busy_count;
    live_stamp_next = live_stamp;
    live_count_next = live_count;
    res.action      = ACT_NONE;
    res.elapsed     = '0;
    if (mode) begin
      live_stamp_next = now;
      live_count_next = '0;
    end else if (!module_busy) begin
      busy_stamp_next = now;
      busy_count_next = '0;
      res.elapsed     = 32'(diff_live);
      if (cmp_t'(diff_live) >= cmp_t'(live_timeout)) begin
        live_stamp_next = now;
        if (live_bumped <= live_limit) begin
          res.action      = ACT_RESTART;
          live_count_next = live_bumped;
        end else begin
          res.action      = ACT_HARD;
          live_count_next = '0;
        end
      end
    end else begin
      res.elapsed = 32'(diff_busy);
      if (cmp_t'(diff_busy) >= cmp_t'(busy_timeout)) begin
        busy_stamp_next = now;
        if (busy_count < soft_limit) begin
          res.action      = ACT_SOFT;
          busy_count_next = bump(busy_count);
        end else begin
          res.action      = ACT_HARD;
          busy_count_next = '0;
        end
      end
    end
    res.busy_rec = busy_count_next;
    res.live_rec = live_count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy_timeout <= BUSY_TIMEOUT_RST;
      soft_limit   <= SOFT_LIMIT_RST;
      live_timeout <= LIVE_TIMEOUT_RST;
      live_limit   <= LIVE_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        REG_BUSY_TIMEOUT: busy_timeout <= cfg_wdata;
        REG_SOFT_LIMIT:   soft_limit   <= cfg_wdata[7:0];
        REG_LIVE_TIMEOUT: live_timeout <= cfg_wdata;
        REG_LIVE_LIMIT:   live_limit   <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy_stamp <= '0;
      busy_count <= '0;
      live_stamp <= '0;
      live_count <= '0;
    end else if (in_take) begin
      busy_stamp <= busy_stamp_next;
      busy_count <= busy_count_next;
      live_stamp <= live_stamp_next;
      live_count <= live_count_next;
    end
  end

  // Result register with a skid entry behind it; skid is empty whenever input is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (in_take) begin
      if (out_valid && !out_take) begin
        skid_res   <= res;
        skid_valid <= 1'b1;
      end else begin
        out_res   <= res;
        out_valid <= 1'b1;
      end
    end else if (out_take) begin
      if (skid_valid) begin
        out_res    <= skid_res;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  assign s_axis_tready = !skid_valid;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(OUT_DATA_W - $bits(result_t)){1'b0}}, out_res};

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held without a result in front");

  a_fill_skid: assert property (@(posedge clk) disable iff (rst)
    (in_take && out_valid && !out_take) |=> skid_valid)
    else $error("result lost while output stalled");

  a_hard_clears: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_res.action == ACT_HARD) |-> out_res.busy_rec == 8'd0)
    else $error("hard reset left a busy recovery count");

  a_soft_counts: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_res.action == ACT_SOFT) |-> out_res.busy_rec != 8'd0)
    else $error("soft recovery without a count");

  a_restart_counts: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_res.action == ACT_RESTART) |->
      (out_res.live_rec != 8'd0 && out_res.busy_rec == 8'd0))
    else $error("restart request with inconsistent counts");

endmodule
